>>> rtl/bdq_pkg.sv
// Package for the bounded deque: request and status codes, field widths, defaults.
package bdq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int OCC_W      = 5;
    localparam int M_TDATA_W  = 40;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bounded_deque.sv
// Bounded double-ended queue: ring of CAPACITY words in one RAM, head/tail pointers and count.
// Accept to m_tvalid: the pending stage (with the RAM read register), then one output register.
// Throughput: one item per cycle while the output is not stalled; pointers and count update at
// accept, the RAM read port delivers popped data in the next cycle.
// Reset (aresetn low, synchronous): pointers, count and valid flags clear; the slot RAM
// is not cleared and holds no defined contents until written.
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] opcode

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] data_out, [36:32] occupancy,
                                            // [37] is_empty, [38] is_full, [39] zero
    output logic [ST_W-1:0]      m_tuser    // [1:0] status
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic            pend_valid_reg, pend_valid_next;
    logic            pend_pop_reg;
    logic [ST_W-1:0] pend_status_reg;
    logic [OCC_W-1:0] pend_occ_reg;
    logic            pend_empty_reg;
    logic            pend_full_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [ST_W-1:0]       m_status_reg;
    logic [OCC_W-1:0]      m_occ_reg;
    logic                  m_empty_reg;
    logic                  m_full_reg;

    logic            accept, pend_move;
    logic            is_push, is_front, push_ok, pop_ok;
    logic [PW-1:0]   head_inc, head_dec, tail_inc, tail_dec;
    logic [PW-1:0]   wr_addr, rd_addr;
    logic [ST_W-1:0] status_new;
    logic [63:0]     wide_in;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [DATA_WIDTH-1:0] rd_word;
    logic signed [DATA_WIDTH-1:0] rd_signed;
    logic [63:0]     rd_ext;

    assign pend_move = pend_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;
    assign accept    = s_tvalid && s_tready;

    assign is_push  = (s_tuser == OP_PUSH_FRONT) || (s_tuser == OP_PUSH_REAR);
    assign is_front = (s_tuser == OP_PUSH_FRONT) || (s_tuser == OP_POP_FRONT);
    assign push_ok  = is_push && (cnt_reg != CNT_FULL);
    assign pop_ok   = !is_push && (cnt_reg != '0);

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PW'(1);
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - PW'(1);
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + PW'(1);
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : tail_reg - PW'(1);

    assign wr_addr = is_front ? head_dec : tail_reg;
    assign rd_addr = is_front ? head_reg : tail_dec;

    assign wide_in = 64'(s_tdata);
    assign wr_word = wide_in[DATA_WIDTH-1:0];

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        status_new = ST_OK;
        if (is_push) begin
            if (!push_ok) begin
                status_new = ST_FULL;
            end else begin
                cnt_next = cnt_reg + CW'(1);
                if (is_front) begin
                    head_next = head_dec;
                end else begin
                    tail_next = tail_inc;
                end
            end
        end else begin
            if (!pop_ok) begin
                status_new = ST_EMPTY;
            end else begin
                cnt_next = cnt_reg - CW'(1);
                if (is_front) begin
                    head_next = head_inc;
                end else begin
                    tail_next = tail_dec;
                end
            end
        end
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (aclk),
        .we    (accept && push_ok),
        .waddr (wr_addr),
        .wdata (wr_word),
        .re    (accept && pop_ok),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    assign rd_signed = rd_word;
    assign rd_ext    = 64'(rd_signed);

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (pend_move) begin
            pend_valid_next = 1'b0;
        end
        if (accept) begin
            pend_valid_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pend_move) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_pop_reg    <= pop_ok;
            pend_status_reg <= status_new;
            pend_occ_reg    <= OCC_W'(cnt_next);
            pend_empty_reg  <= (cnt_next == '0);
            pend_full_reg   <= (cnt_next == CNT_FULL);
        end
        if (pend_move) begin
            m_data_reg   <= pend_pop_reg ? rd_ext[OUT_DATA_W-1:0] : '0;
            m_status_reg <= pend_status_reg;
            m_occ_reg    <= pend_occ_reg;
            m_empty_reg  <= pend_empty_reg;
            m_full_reg   <= pend_full_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_full_reg, m_empty_reg, m_occ_reg, m_data_reg};
    assign m_tuser  = m_status_reg;

endmodule

>>> rtl/bdq_checker.sv
// Port-level checker for the bounded deque, bound to the top level.
module bdq_checker
    import bdq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [ST_W-1:0]      m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[38] && !m_tdata[37])
        else $error("refused push without full flag");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[37] && !m_tdata[38]
            && (m_tdata[36:32] == '0))
        else $error("refused pop without empty flag");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("refused item carries data");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb_bounded_deque.sv
// Testbench for bounded_deque: ring-buffer prediction, random stream traffic, result checks.
import bdq_pkg::*;

typedef struct packed {
    logic [OUT_DATA_W-1:0] data_out;
    logic [ST_W-1:0]       status;
    logic [OCC_W-1:0]      occupancy;
    logic                  is_empty;
    logic                  is_full;
} deque_reply_t;

class deque_scoreboard;
    logic [DEF_DATA_WIDTH-1:0] ring [DEF_CAPACITY];
    int                        front_idx;
    int                        rear_idx;
    int                        fill_count;
    deque_reply_t              pending_replies[$];
    int                        mismatches;

    function new();
        front_idx  = 0;
        rear_idx   = 0;
        fill_count = 0;
        mismatches = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] word);
        deque_reply_t rep;
        rep.data_out = '0;
        rep.status   = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (fill_count == DEF_CAPACITY) begin
                    rep.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    front_idx = (front_idx == 0) ? DEF_CAPACITY - 1 : front_idx - 1;
                    ring[front_idx] = word;
                    fill_count++;
                end else begin
                    ring[rear_idx] = word;
                    rear_idx = (rear_idx == DEF_CAPACITY - 1) ? 0 : rear_idx + 1;
                    fill_count++;
                end
            end
            OP_POP_FRONT: begin
                if (fill_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    rep.data_out = ring[front_idx];
                    front_idx = (front_idx == DEF_CAPACITY - 1) ? 0 : front_idx + 1;
                    fill_count--;
                end
            end
            default: begin
                if (fill_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    rear_idx = (rear_idx == 0) ? DEF_CAPACITY - 1 : rear_idx - 1;
                    rep.data_out = ring[rear_idx];
                    fill_count--;
                end
            end
        endcase
        rep.occupancy = OCC_W'(fill_count);
        rep.is_empty  = (fill_count == 0);
        rep.is_full   = (fill_count == DEF_CAPACITY);
        pending_replies.push_back(rep);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [ST_W-1:0] tuser);
        deque_reply_t got;
        deque_reply_t want;
        got.data_out  = tdata[31:0];
        got.occupancy = tdata[36:32];
        got.is_empty  = tdata[37];
        got.is_full   = tdata[38];
        got.status    = tuser;
        if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: data %h status %0d occ %0d empty %b full %b",
                         got.data_out, got.status, got.occupancy, got.is_empty,
                         got.is_full);
            return;
        end
        want = pending_replies.pop_front();
        if (got.data_out !== want.data_out || got.status !== want.status ||
            got.occupancy !== want.occupancy || got.is_empty !== want.is_empty ||
            got.is_full !== want.is_full || tdata[39] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp data %h st %0d occ %0d e %b f %b",
                          " | got data %h st %0d occ %0d e %b f %b pad %b"},
                         want.data_out, want.status, want.occupancy, want.is_empty,
                         want.is_full, got.data_out, got.status, got.occupancy,
                         got.is_empty, got.is_full, tdata[39]);
        end
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction
endclass

module tb_bounded_deque;
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;

    deque_scoreboard sb;

    bounded_deque DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] word);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, word);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    function automatic logic [IN_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // fill, drain or balanced runs so both full and empty are visited often
    task automatic random_traffic(int total);
        int sent;
        int run_left;
        int push_pct;
        int burst_left;
        logic [OP_W-1:0] op;
        sent       = 0;
        run_left   = 0;
        push_pct   = 50;
        burst_left = 0;
        while (sent < total) begin
            if (run_left == 0) begin
                run_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 6));
            end
            if ($urandom_range(1, 100) <= push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            send_item(op, pick_word());
            sent++;
            run_left--;
            burst_left--;
        end
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            int mode;
            int span;
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 100);
            for (int i = 0; i < span; i++) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (i % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        int i;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PUSH_FRONT;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty pops, extremes through both ends, head wrap below zero
        send_item(OP_POP_FRONT,  32'h1234_5678);
        send_item(OP_POP_REAR,   32'hFFFF_FFFF);
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(OP_PUSH_REAR,  32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'h0000_0000);
        send_item(OP_PUSH_REAR,  32'hFFFF_FFFF);
        send_item(OP_POP_REAR,   32'h0);
        send_item(OP_POP_FRONT,  32'h0);
        send_item(OP_POP_FRONT,  32'h0);
        send_item(OP_POP_REAR,   32'h0);
        // fill to capacity, then refused pushes
        for (i = 0; i < DEF_CAPACITY; i++)
            send_item(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, $urandom);
        send_item(OP_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(OP_PUSH_REAR,  32'h5A5A_5A5A);

        random_traffic(900);
        idle_sender(1);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bounded_deque.sv
rtl/bdq_checker.sv
test/tb_bounded_deque.sv
